@@ src/conv1d_full_valid_same_macros.svh @@
// ---------------------------------------------------------------------------
// conv1d_full_valid_same assertion macros
// Short forms for the concurrent checks of the convolution block.
// ---------------------------------------------------------------------------
`ifndef CONV1D_FULL_VALID_SAME_MACROS_SVH
`define CONV1D_FULL_VALID_SAME_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define CFV_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("conv1d_full_valid_same: same-cycle check failed");

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define CFV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("conv1d_full_valid_same: next-cycle check failed");

`endif

@@ src/cfv_pkg.sv @@
// ---------------------------------------------------------------------------
// cfv_pkg
// Shared constants, codes and types of the 1-D convolution block.
// ---------------------------------------------------------------------------
package cfv_pkg;

    localparam int MAX_TAPS_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LENGTH_BITS_DEF = 16;

    localparam int RESULT_W   = 40;
    localparam int POS_W      = 17;
    localparam int TAP_IDX_W  = 6;
    localparam int MODE_W     = 2;
    localparam int SLEN_W     = 16;
    localparam int KLEN_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_FULL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VALID = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SAME  = 2'd2;

    localparam logic CMD_TAP    = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KLEN = 2'd2;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic shift;
        logic clear;
        logic snap;
        logic roll;
        logic tap_we;
    } cell_ctl_t;

    // Output window decision for the current full-convolution point.
    typedef struct packed {
        logic             keep;
        logic             last;
        logic [POS_W-1:0] pos;
    } win_t;

endpackage

@@ src/cfv_cell.sv @@
// ---------------------------------------------------------------------------
// cfv_cell
// One tap cell: delay-line sample, kernel tap, and a product stage that
// hands its product to the neighbor toward the accumulator.
// ---------------------------------------------------------------------------
module cfv_cell #(
    parameter int SAMPLE_BITS = cfv_pkg::SAMPLE_BITS_DEF,
    parameter int KW          = 7,
    parameter int INDEX       = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cfv_pkg::cell_ctl_t                     ctl,
    input  logic [KW-1:0]                          eff_k,
    input  logic [cfv_pkg::TAP_IDX_W-1:0]          tap_index,
    input  logic [SAMPLE_BITS-1:0]                 tap_value,
    input  logic [SAMPLE_BITS-1:0]                 sample_in,
    output logic [SAMPLE_BITS-1:0]                 sample_out,
    input  logic signed [cfv_pkg::RESULT_W-1:0]    prod_in,
    output logic signed [cfv_pkg::RESULT_W-1:0]    prod_out
);
    import cfv_pkg::*;

    logic [SAMPLE_BITS-1:0]        sample_reg;
    logic [SAMPLE_BITS-1:0]        sample_next;
    logic [SAMPLE_BITS-1:0]        tap_reg;
    logic [SAMPLE_BITS-1:0]        tap_next;
    logic signed [RESULT_W-1:0]    prod_reg;
    logic signed [RESULT_W-1:0]    prod_next;
    logic signed [2*SAMPLE_BITS-1:0] mult;
    logic                          in_use;
    logic                          tap_hit;

    assign in_use  = KW'(INDEX) < eff_k;
    assign tap_hit = tap_index == TAP_IDX_W'(INDEX);
    assign mult    = $signed(sample_reg) * $signed(tap_reg);

    always_comb
    begin
        sample_next = sample_reg;
        if (ctl.clear)
        begin
            sample_next = '0;
        end
        else if (ctl.shift)
        begin
            sample_next = sample_in;
        end

        tap_next = tap_reg;
        if (ctl.tap_we && tap_hit)
        begin
            tap_next = tap_value;
        end

        // Taps beyond the kernel length contribute nothing to the point.
        prod_next = prod_reg;
        if (ctl.snap)
        begin
            prod_next = in_use ? RESULT_W'(mult) : '0;
        end
        else if (ctl.roll)
        begin
            prod_next = prod_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tap_reg  <= tap_next;
        prod_reg <= prod_next;
    end

    assign sample_out = sample_reg;
    assign prod_out   = prod_reg;

endmodule

@@ src/cfv_window.sv @@
// ---------------------------------------------------------------------------
// cfv_window
// Output window bounds for full, valid and same modes, and the keep,
// position and last decision for one full-convolution point.
// ---------------------------------------------------------------------------
module cfv_window #(
    parameter int KW = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [cfv_pkg::MODE_W-1:0]     mode,
    input  logic [cfv_pkg::SLEN_W-1:0]     eff_len,
    input  logic [KW-1:0]                  eff_k,
    input  logic [cfv_pkg::POS_W-1:0]      full_index,
    output cfv_pkg::win_t                  win
);
    import cfv_pkg::*;

    logic [POS_W-1:0] len_w;
    logic [POS_W-1:0] k_w;
    logic [POS_W-1:0] full_w;
    logic [POS_W-1:0] off_next;
    logic [POS_W-1:0] size_next;
    logic             en_next;
    logic [POS_W-1:0] off_reg;
    logic [POS_W-1:0] size_reg;
    logic             en_reg;
    logic [POS_W-1:0] diff;

    assign len_w  = POS_W'(eff_len);
    assign k_w    = POS_W'(eff_k);
    assign full_w = len_w + k_w - POS_W'(1);

    always_comb
    begin
        off_next  = '0;
        size_next = '0;
        en_next   = 1'b0;
        unique case (mode)
            MODE_FULL:
            begin
                size_next = full_w;
                en_next   = 1'b1;
            end
            MODE_VALID:
            begin
                off_next  = k_w - POS_W'(1);
                size_next = (len_w >= k_w) ? len_w - k_w + POS_W'(1) : '0;
                en_next   = 1'b1;
            end
            MODE_SAME:
            begin
                size_next = (len_w > k_w) ? len_w : k_w;
                off_next  = (full_w - size_next) >> 1;
                en_next   = 1'b1;
            end
            default:
            begin
                en_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg  <= '0;
            size_reg <= '0;
            en_reg   <= 1'b0;
        end
        else
        begin
            off_reg  <= off_next;
            size_reg <= size_next;
            en_reg   <= en_next;
        end
    end

    assign diff     = full_index - off_reg;
    assign win.keep = en_reg && (full_index >= off_reg) && (diff < size_reg);
    assign win.pos  = diff;
    assign win.last = diff == (size_reg - POS_W'(1));

endmodule

@@ src/conv1d_full_valid_same.sv @@
// ---------------------------------------------------------------------------
// conv1d_full_valid_same
// Streaming 1-D convolution with full, valid and same output windows.
//
// Tap beats (tuser 0) write one kernel word into the cell chain; sample
// beats (tuser 1) shift the sample into the delay line held by the cells
// and form one full-convolution point. Each point is formed by capturing
// all tap products in the cells at once and then rolling them down the
// chain into a single 40-bit accumulator, one cell per cycle, with K the
// kernel length in use. The block takes no new beat until it is done with
// the last one; the sample that closes a run (signal_length samples) also
// flushes the tail with K-1 more points. A point that falls inside the
// selected window is held in an output register, and the sequencer waits
// there only when that register is still occupied. Mode 3 drops every
// point. Kernel taps read as unknown until written.
// ---------------------------------------------------------------------------
`include "conv1d_full_valid_same_macros.svh"

module conv1d_full_valid_same #(
    parameter int MAX_TAPS    = cfv_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = cfv_pkg::SAMPLE_BITS_DEF,
    parameter int LENGTH_BITS = cfv_pkg::LENGTH_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [cfv_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cfv_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // value, tap_index, zero fill
    input  logic [((SAMPLE_BITS + cfv_pkg::TAP_IDX_W + 7) / 8) * 8 - 1:0] s_tdata,
    // cmd
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // result, position, zero fill
    output logic [((cfv_pkg::RESULT_W + cfv_pkg::POS_W + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                  m_tlast
);
    import cfv_pkg::*;

    localparam int OUT_W = ((RESULT_W + POS_W + 7) / 8) * 8;
    localparam int KW    = $clog2(MAX_TAPS + 1);
    localparam int FW    = $clog2(MAX_TAPS);
    localparam int CW    = (LENGTH_BITS > SLEN_W) ? LENGTH_BITS : SLEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SNAP,
        S_ACC,
        S_EMIT
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic                       item_cmd_reg;
    logic                       item_cmd_next;
    logic [SAMPLE_BITS-1:0]     item_value_reg;
    logic [SAMPLE_BITS-1:0]     item_value_next;
    logic [TAP_IDX_W-1:0]       item_idx_reg;
    logic [TAP_IDX_W-1:0]       item_idx_next;
    logic [MODE_W-1:0]          mode_reg;
    logic [MODE_W-1:0]          mode_next;
    logic [SLEN_W-1:0]          slen_reg;
    logic [SLEN_W-1:0]          slen_next;
    logic [KLEN_W-1:0]          klen_reg;
    logic [KLEN_W-1:0]          klen_next;
    logic [LENGTH_BITS-1:0]     samples_reg;
    logic [LENGTH_BITS-1:0]     samples_next;
    logic [POS_W-1:0]           full_index_reg;
    logic [POS_W-1:0]           full_index_next;
    logic                       flush_reg;
    logic                       flush_next;
    logic [FW-1:0]              flush_left_reg;
    logic [FW-1:0]              flush_left_next;
    logic [KW-1:0]              acc_cnt_reg;
    logic [KW-1:0]              acc_cnt_next;
    logic signed [RESULT_W-1:0] acc_reg;
    logic signed [RESULT_W-1:0] acc_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [RESULT_W-1:0]        out_result_reg;
    logic [RESULT_W-1:0]        out_result_next;
    logic [POS_W-1:0]           out_pos_reg;
    logic [POS_W-1:0]           out_pos_next;
    logic                       out_last_reg;
    logic                       out_last_next;

    logic [SLEN_W-1:0]          eff_len;
    logic [KW-1:0]              eff_k;
    logic [LENGTH_BITS-1:0]     ss_inc;
    logic                       run_end;
    logic                       out_free;
    logic                       out_load;
    logic [SAMPLE_BITS-1:0]     shift_value;
    cell_ctl_t                  ctl;
    win_t                       win;

    logic [SAMPLE_BITS-1:0]     sample_chain [0:MAX_TAPS];
    logic signed [RESULT_W-1:0] prod_chain [0:MAX_TAPS];

    // A zero length means one; a kernel longer than the chain is clipped.
    assign eff_len = (slen_reg == '0) ? SLEN_W'(1) : slen_reg;
    assign eff_k   = (klen_reg == '0) ? KW'(1) :
                     (klen_reg > KLEN_W'(MAX_TAPS)) ? KW'(MAX_TAPS) : KW'(klen_reg);

    assign ss_inc   = samples_reg + LENGTH_BITS'(1);
    assign run_end  = (ss_inc == '0) || (CW'(ss_inc) >= CW'(eff_len));
    assign out_free = !out_valid_reg || m_tready;

    assign sample_chain[0]        = shift_value;
    assign prod_chain[MAX_TAPS]   = '0;

    for (genvar j = 0; j < MAX_TAPS; j++)
    begin : g_cell
        cfv_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .KW          (KW),
            .INDEX       (j)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .eff_k      (eff_k),
            .tap_index  (item_idx_reg),
            .tap_value  (item_value_reg),
            .sample_in  (sample_chain[j]),
            .sample_out (sample_chain[j+1]),
            .prod_in    (prod_chain[j+1]),
            .prod_out   (prod_chain[j])
        );
    end

    cfv_window #(
        .KW (KW)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .eff_len    (eff_len),
        .eff_k      (eff_k),
        .full_index (full_index_reg),
        .win        (win)
    );

    always_comb
    begin
        state_next      = state_reg;
        item_cmd_next   = item_cmd_reg;
        item_value_next = item_value_reg;
        item_idx_next   = item_idx_reg;
        mode_next       = mode_reg;
        slen_next       = slen_reg;
        klen_next       = klen_reg;
        samples_next    = samples_reg;
        full_index_next = full_index_reg;
        flush_next      = flush_reg;
        flush_left_next = flush_left_reg;
        acc_cnt_next    = acc_cnt_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_result_next = out_result_reg;
        out_pos_next    = out_pos_reg;
        out_last_next   = out_last_reg;
        out_load        = 1'b0;
        shift_value     = '0;
        ctl             = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE: mode_next = cfg_data[MODE_W-1:0];
                REG_SLEN: slen_next = cfg_data[SLEN_W-1:0];
                REG_KLEN: klen_next = cfg_data[KLEN_W-1:0];
                default:  ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    item_cmd_next   = s_tuser;
                    item_value_next = s_tdata[SAMPLE_BITS-1:0];
                    item_idx_next   = s_tdata[SAMPLE_BITS +: TAP_IDX_W];
                    state_next      = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (item_cmd_reg == CMD_TAP)
                begin
                    ctl.tap_we = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.shift       = 1'b1;
                    shift_value     = item_value_reg;
                    samples_next    = run_end ? '0 : ss_inc;
                    flush_next      = run_end;
                    flush_left_next = run_end ? FW'(eff_k - KW'(1)) : '0;
                    state_next      = S_SNAP;
                end
            end
            S_SNAP:
            begin
                ctl.snap     = 1'b1;
                acc_next     = '0;
                acc_cnt_next = eff_k;
                state_next   = S_ACC;
            end
            S_ACC:
            begin
                ctl.roll     = 1'b1;
                acc_next     = acc_reg + prod_chain[0];
                acc_cnt_next = acc_cnt_reg - KW'(1);
                if (acc_cnt_reg == KW'(1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // Hold the point until the output register can take it.
                if (!win.keep || out_free)
                begin
                    if (win.keep)
                    begin
                        out_load        = 1'b1;
                        out_valid_next  = 1'b1;
                        out_result_next = acc_reg;
                        out_pos_next    = win.pos;
                        out_last_next   = win.last;
                    end
                    if (flush_left_reg != '0)
                    begin
                        ctl.shift       = 1'b1;
                        flush_left_next = flush_left_reg - FW'(1);
                        full_index_next = full_index_reg + POS_W'(1);
                        state_next      = S_SNAP;
                    end
                    else if (flush_reg)
                    begin
                        ctl.clear       = 1'b1;
                        full_index_next = '0;
                        flush_next      = 1'b0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        full_index_next = full_index_reg + POS_W'(1);
                        state_next      = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_cmd_reg   <= CMD_TAP;
            item_value_reg <= '0;
            item_idx_reg   <= '0;
            mode_reg       <= MODE_FULL;
            slen_reg       <= SLEN_W'(1);
            klen_reg       <= KLEN_W'(1);
            samples_reg    <= '0;
            full_index_reg <= '0;
            flush_reg      <= 1'b0;
            flush_left_reg <= '0;
            acc_cnt_reg    <= '0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_result_reg <= '0;
            out_pos_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            item_cmd_reg   <= item_cmd_next;
            item_value_reg <= item_value_next;
            item_idx_reg   <= item_idx_next;
            mode_reg       <= mode_next;
            slen_reg       <= slen_next;
            klen_reg       <= klen_next;
            samples_reg    <= samples_next;
            full_index_reg <= full_index_next;
            flush_reg      <= flush_next;
            flush_left_reg <= flush_left_next;
            acc_cnt_reg    <= acc_cnt_next;
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
            out_result_reg <= out_result_next;
            out_pos_reg    <= out_pos_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_W - RESULT_W - POS_W){1'b0}}, out_pos_reg, out_result_reg};

    `CFV_ASSERT_IMPL(a_acc_count_live, state_reg == S_ACC, acc_cnt_reg != '0)
    `CFV_ASSERT_IMPL(a_no_overwrite, out_load, !out_valid_reg || m_tready)
    `CFV_ASSERT_NEXT(a_run_restart, state_reg == S_EMIT && flush_reg && flush_left_reg == '0 && (!win.keep || out_free), full_index_reg == '0 && samples_reg == '0)

endmodule
